// ===== rtl/ffsa_pkg.sv =====
// ffsa_pkg: beat types, opcodes, controller states and the command/status
// structs shared by the first-fit slot allocator modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ffsa_pkg;

    localparam int ROW_BITS  = 32;
    localparam int ROW_SHIFT = 5;
    localparam int FB_W      = 13;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_PLACE,
        ST_WR_RD,
        ST_WR_MOD,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [6:0]         size_bytes;
        logic signed [15:0] release_offset;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] frame_offset;
        logic [10:0]        slot_index;
        logic               overflow;
        logic [11:0]        high_water;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic decide;
        logic scan_step;
        logic place;
        logic wr_row;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic bad_len;
        logic free_ok;
        logic mark_zero;
        logic hit;
        logic stop;
        logic fit;
        logic last_row;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/ffsa_ctrl.sv =====
// ffsa_ctrl: sequencing state machine for decode, map scan, placement and
// read-modify-write of map rows; owns the handshakes; uses ffsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire          i_out_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   out_free;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                case (i_sts.op)
                    OP_ALLOC: begin
                        if (i_sts.bad_len)        n_state = ST_FINISH;
                        else if (i_sts.mark_zero) n_state = ST_PLACE;
                        else                      n_state = ST_SCAN_RD;
                    end
                    OP_FREE: begin
                        if (!i_sts.bad_len && i_sts.free_ok) n_state = ST_WR_RD;
                        else                                 n_state = ST_FINISH;
                    end
                    default: n_state = ST_FINISH;
                endcase
            end
            ST_SCAN_RD:  n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (i_sts.hit || i_sts.stop) n_state = ST_PLACE;
                else                         n_state = ST_SCAN_RD;
            end
            ST_PLACE: begin
                if (i_sts.fit) n_state = ST_WR_RD;
                else           n_state = ST_FINISH;
            end
            ST_WR_RD:  n_state = ST_WR_MOD;
            ST_WR_MOD: begin
                if (i_sts.last_row) n_state = ST_FINISH;
                else                n_state = ST_WR_RD;
            end
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        n_out_vld = r_out_vld && i_out_stall;
        case (r_state)
            ST_IDLE:     o_cmd.load      = i_in_valid;
            ST_DECIDE:   o_cmd.decide    = 1'b1;
            ST_SCAN_CHK: o_cmd.scan_step = 1'b1;
            ST_PLACE:    o_cmd.place     = 1'b1;
            ST_WR_MOD:   o_cmd.wr_row    = 1'b1;
            ST_FINISH: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ffsa_dp.sv =====
// ffsa_dp: slot map row memory with row valid bits, high-water mark,
// first-fit row window search, run placement and result registers; uses ffsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module ffsa_dp
    import ffsa_pkg::*;
#(
    parameter int SLOTS         = 2048,
    parameter int MAX_RUN_WORDS = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire  [FB_W-1:0]  i_cfg_wdata,
    input  wire  t_in_beat   i_in_beat,
    input  wire  t_dp_cmd    i_cmd,
    output t_dp_sts          o_sts,
    output t_out_beat        o_out_beat
);

    localparam int ROWS = (SLOTS + ROW_BITS - 1) / ROW_BITS;
    localparam int RA   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MW   = $clog2(SLOTS + 1);
    localparam int CW   = ((MW > 16) ? MW : 16) + 2;
    localparam int M    = MAX_RUN_WORDS;
    localparam int WINW = ROW_BITS + M;

    logic [ROW_BITS-1:0] r_mem [ROWS];
    logic [ROW_BITS-1:0] r_rd;
    logic                r_rd_vld;
    logic [ROWS-1:0]     r_row_vld;

    logic [FB_W-1:0]     r_fb;
    logic [MW-1:0]       r_mark;
    t_op                 r_op;
    logic [6:0]          r_words;
    logic signed [15:0]  r_roff;
    logic [RA-1:0]       r_row;
    logic [RA-1:0]       r_end_row;
    logic [M-1:0]        r_tail;
    logic                r_hit;
    logic [CW-1:0]       r_cand;
    logic [CW-1:0]       r_start;
    logic [CW-1:0]       r_run_end;
    logic signed [15:0]  r_res_off;
    logic [10:0]         r_res_slot;
    logic                r_res_ovf;
    t_out_beat           r_out;

    logic [6:0]          words_in;
    logic                bad_len;
    logic [18:0]         fbyte;
    logic [CW-1:0]       free_start;
    logic [CW-1:0]       free_end;
    logic                free_ok;
    logic [CW-1:0]       row_base;
    logic [ROW_BITS-1:0] used;
    logic [ROW_BITS-1:0] free_row;
    logic [WINW-1:0]     window;
    logic [ROW_BITS-1:0] hit_vec;
    logic                hit_any;
    logic [ROW_SHIFT-1:0] first;
    logic [CW-1:0]       cand;
    logic                stop;
    logic                use_cand;
    logic [CW-1:0]       place_start;
    logic [CW-1:0]       place_end;
    logic                fit;
    logic [15:0]         start16;
    logic [15:0]         place_off;
    logic [ROW_BITS-1:0] run_mask;
    logic [ROW_BITS-1:0] wdata;

    assign words_in = 7'((8'(i_in_beat.size_bytes) + 8'd3) >> 2);
    assign bad_len  = (r_words == 7'd0) || (r_words > 7'(M));

    // free start byte, 19-bit two's complement
    assign fbyte      = 19'd0 - {{3{r_roff[15]}}, r_roff} - 19'({r_words, 2'b00})
                      - 19'(r_fb);
    assign free_start = CW'(fbyte[17:2]);
    assign free_end   = free_start + CW'(r_words);
    assign free_ok    = !fbyte[18] && (free_end <= CW'(SLOTS));

    assign row_base = CW'({r_row, {ROW_SHIFT{1'b0}}});
    assign used     = r_rd_vld ? r_rd : '0;

    always_comb begin
        for (int b = 0; b < ROW_BITS; b++) begin
            free_row[b] = !used[b] && ((row_base + CW'(b)) < CW'(SLOTS));
            run_mask[b] = ((row_base + CW'(b)) >= r_start)
                       && ((row_base + CW'(b)) < r_run_end);
        end
    end

    assign window = {free_row, r_tail};

    // run of r_words free slots ending at each bit of this row
    always_comb begin
        for (int j = 0; j < ROW_BITS; j++) begin
            hit_vec[j] = 1'b1;
            for (int k = 0; k < M; k++) begin
                if (7'(k) < r_words && !window[M + j - k]) hit_vec[j] = 1'b0;
            end
        end
    end

    always_comb begin
        hit_any = 1'b0;
        first   = '0;
        for (int j = ROW_BITS - 1; j >= 0; j--) begin
            if (hit_vec[j]) begin
                hit_any = 1'b1;
                first   = ROW_SHIFT'(j);
            end
        end
    end

    assign cand = row_base + CW'(first) + CW'(1) - CW'(r_words);
    assign stop = (r_row == RA'(ROWS - 1))
               || ((row_base + CW'(ROW_BITS)) >= (CW'(r_mark) + CW'(r_words)));

    assign use_cand    = r_hit && (r_cand < CW'(r_mark));
    assign place_start = use_cand ? r_cand : CW'(r_mark);
    assign place_end   = place_start + CW'(r_words);
    assign fit         = place_end <= CW'(SLOTS);
    assign start16     = 16'(place_start);
    assign place_off   = 16'd0 - (start16 << 2) - 16'({r_words, 2'b00}) - 16'(r_fb);

    assign wdata = (r_op == OP_ALLOC) ? (used | run_mask) : (used & ~run_mask);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_row) r_mem[r_row] <= wdata;
        r_rd <= r_mem[r_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_mark    <= '0;
            r_fb      <= '0;
        end else begin
            r_rd_vld <= r_row_vld[r_row];
            if (i_cfg_we) r_fb <= i_cfg_wdata;
            if (i_cmd.wr_row) r_row_vld[r_row] <= 1'b1;
            if (i_cmd.decide && r_op == OP_CLEAR) begin
                r_row_vld <= '0;
                r_mark    <= '0;
            end
            if (i_cmd.place && fit && (place_end > CW'(r_mark))) begin
                r_mark <= MW'(place_end);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= t_op'(i_in_beat.cmd);
            r_words    <= words_in;
            r_roff     <= i_in_beat.release_offset;
            r_res_off  <= '0;
            r_res_slot <= '0;
            r_res_ovf  <= 1'b0;
        end
        if (i_cmd.decide) begin
            r_tail <= '0;
            r_hit  <= 1'b0;
            if (r_op == OP_FREE && !bad_len && free_ok) r_row <= RA'(free_start >> ROW_SHIFT);
            else                                        r_row <= '0;
            if ((r_op == OP_ALLOC || r_op == OP_FREE) && bad_len) r_res_ovf <= 1'b1;
            if (r_op == OP_FREE && !bad_len) begin
                if (free_ok) begin
                    r_start    <= free_start;
                    r_run_end  <= free_end;
                    r_end_row  <= RA'((free_end - CW'(1)) >> ROW_SHIFT);
                    r_res_slot <= 11'(free_start);
                end else begin
                    r_res_ovf <= 1'b1;
                end
            end
        end
        if (i_cmd.scan_step) begin
            r_tail <= window[WINW-1:ROW_BITS];
            r_row  <= r_row + RA'(1);
            if (hit_any) begin
                r_hit  <= 1'b1;
                r_cand <= cand;
            end
        end
        if (i_cmd.place) begin
            if (fit) begin
                r_start    <= place_start;
                r_run_end  <= place_end;
                r_row      <= RA'(place_start >> ROW_SHIFT);
                r_end_row  <= RA'((place_end - CW'(1)) >> ROW_SHIFT);
                r_res_off  <= place_off;
                r_res_slot <= 11'(place_start);
            end else begin
                r_res_ovf <= 1'b1;
            end
        end
        if (i_cmd.wr_row) r_row <= r_row + RA'(1);
        if (i_cmd.out_load) begin
            r_out.frame_offset <= r_res_off;
            r_out.slot_index   <= r_res_slot;
            r_out.overflow     <= r_res_ovf;
            r_out.high_water   <= 12'(r_mark);
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.bad_len   = bad_len;
    assign o_sts.free_ok   = free_ok;
    assign o_sts.mark_zero = (r_mark == '0);
    assign o_sts.hit       = hit_any;
    assign o_sts.stop      = stop;
    assign o_sts.fit       = fit;
    assign o_sts.last_row  = (r_row == r_end_row);
    assign o_out_beat      = r_out;

endmodule

`default_nettype wire

// ===== rtl/first_fit_stack_slot_allocator.sv =====
// first_fit_stack_slot_allocator: one beat in, one result beat out per item.
// Clear, no-op, bad lengths and refused frees go from decode to the result; a free rewrites
// each map row it covers; an allocate scans 32-slot rows (skipped while the mark is zero),
// then places the run and rewrites its rows. One item at a time, a scan of up to 64 rows.
// Reset: synchronous, clears the row valid bits (map reads all free), the mark and the frame base.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_stack_slot_allocator
    import ffsa_pkg::*;
#(
    parameter int SLOTS         = 2048,
    parameter int MAX_RUN_WORDS = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cfg_we,
    input  wire  [FB_W-1:0] i_cfg_wdata,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  wire  t_in_beat  i_in_beat,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    output t_out_beat       o_out_beat
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    ffsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    ffsa_dp #(
        .SLOTS         (SLOTS),
        .MAX_RUN_WORDS (MAX_RUN_WORDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_beat   (i_in_beat),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_beat  (o_out_beat)
    );

endmodule

`default_nettype wire

// ===== verif/ffsa_slot_checker.sv =====
`timescale 1ns / 1ps
// ffsa_slot_checker: watches the item and result channels of the slot allocator,
// keeps its own slot map, mark and frame base, and checks every result beat in order
// depends on ffsa_pkg
module ffsa_slot_checker
    import ffsa_pkg::*;
#(
    parameter int SLOT_COUNT = 2048,
    parameter int RUN_LIMIT  = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_cfg_we,
    input  wire [FB_W-1:0] i_cfg_wdata,
    input  wire            i_in_valid,
    input  wire            i_in_stall,
    input  t_in_beat       i_in_beat,
    input  wire            i_out_valid,
    input  wire            i_out_stall,
    input  t_out_beat      i_out_beat,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_checked
);

    bit        used_map [SLOT_COUNT];
    int        high_mark;
    int        base_bytes;
    t_out_beat expected_results[$];

    function automatic bit run_fits(int first, int words);
        if (first + words > SLOT_COUNT) return 1'b0;
        for (int k = 0; k < words; k++)
            if (used_map[first + k]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_out_beat next_slot_result(t_in_beat b);
        t_out_beat r;
        int        words;
        bit        bad_len;
        int        first;
        int        byte_pos;
        r        = '0;
        words    = (int'(b.size_bytes) + 3) >> 2;
        bad_len  = (words == 0) || (words > RUN_LIMIT);
        case (b.cmd)
            OP_ALLOC: begin
                if (bad_len) begin
                    r.overflow = 1'b1;
                end else begin
                    first = high_mark;
                    for (int i = 0; i < high_mark; i++) begin
                        if (run_fits(i, words)) begin
                            first = i;
                            break;
                        end
                    end
                    if (first + words > SLOT_COUNT) begin
                        r.overflow = 1'b1;
                    end else begin
                        for (int k = 0; k < words; k++) used_map[first + k] = 1'b1;
                        if (first + words > high_mark) high_mark = first + words;
                        r.slot_index   = 11'(first);
                        r.frame_offset = 16'(-(4 * first) - 4 * words - base_bytes);
                    end
                end
            end
            OP_FREE: begin
                byte_pos = -int'($signed(b.release_offset)) - 4 * words - base_bytes;
                if (bad_len || byte_pos < 0) begin
                    r.overflow = 1'b1;
                end else if ((byte_pos >>> 2) + words > SLOT_COUNT) begin
                    r.overflow = 1'b1;
                end else begin
                    first = byte_pos >>> 2;
                    for (int k = 0; k < words; k++) used_map[first + k] = 1'b0;
                    r.slot_index = 11'(first);
                end
            end
            OP_CLEAR: begin
                foreach (used_map[k]) used_map[k] = 1'b0;
                high_mark = 0;
            end
            default: ;
        endcase
        r.high_water = 12'(high_mark);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_out_beat want;
        if (!i_rst_n) begin
            foreach (used_map[k]) used_map[k] = 1'b0;
            high_mark    = 0;
            base_bytes   = 0;
            o_fail_count = 0;
            o_checked    = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) base_bytes = int'(i_cfg_wdata);
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%t unexpected result beat: off %0d slot %0d ovf %0b hw %0d",
                                 $realtime, $signed(i_out_beat.frame_offset),
                                 i_out_beat.slot_index, i_out_beat.overflow,
                                 i_out_beat.high_water);
                end else begin
                    want = expected_results.pop_front();
                    o_checked++;
                    if (i_out_beat.frame_offset !== want.frame_offset ||
                        i_out_beat.slot_index !== want.slot_index ||
                        i_out_beat.overflow !== want.overflow ||
                        i_out_beat.high_water !== want.high_water) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $write("%t result mismatch: expected off %0d slot %0d ovf %0b hw %0d",
                                   $realtime, $signed(want.frame_offset), want.slot_index,
                                   want.overflow, want.high_water);
                            $display(", got off %0d slot %0d ovf %0b hw %0d",
                                     $signed(i_out_beat.frame_offset), i_out_beat.slot_index,
                                     i_out_beat.overflow, i_out_beat.high_water);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(next_slot_result(i_in_beat));
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== verif/tb_first_fit_stack_slot_allocator.sv =====
`timescale 1ns / 1ps
// tb_first_fit_stack_slot_allocator: drives directed and random allocate, free and clear
// beats under several frame bases and idle patterns; verdict from ffsa_slot_checker
// depends on ffsa_pkg, first_fit_stack_slot_allocator and ffsa_slot_checker
module tb_first_fit_stack_slot_allocator;
    import ffsa_pkg::*;

    localparam int SLOT_COUNT  = 2048;
    localparam int RUN_LIMIT   = 16;
    localparam int CYCLE_LIMIT = 800000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 270;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_cfg_we    = 1'b0;
    logic [FB_W-1:0] i_cfg_wdata = '0;
    logic            i_in_valid  = 1'b0;
    t_in_beat        i_in_beat   = '0;
    logic            i_out_stall = 1'b0;
    logic            o_in_stall;
    logic            o_out_valid;
    t_out_beat       o_out_beat;

    int       fail_count;
    int       pending;
    int       checked;
    int       in_idle_pct   = 0;
    int       out_idle_pct  = 0;
    bit       pressure_go   = 1'b0;
    int       hold_cycles   = 0;
    int       cycle_count   = 0;
    int       items_sent    = 0;
    int       map_full_hits = 0;
    int       bases [4];
    t_in_beat sent_items[$];
    int       live_off[$];
    int       live_size[$];
    t_in_beat done_item;

    first_fit_stack_slot_allocator #(
        .SLOTS        (SLOT_COUNT),
        .MAX_RUN_WORDS(RUN_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_beat (o_out_beat)
    );

    ffsa_slot_checker #(
        .SLOT_COUNT(SLOT_COUNT),
        .RUN_LIMIT (RUN_LIMIT)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_beat  (o_out_beat),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stall, with one long hold-off once pressure is requested
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (pressure_go && hold_cycles < LONG_HOLD) begin
            i_out_stall <= 1'b1;
            hold_cycles = hold_cycles + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // track live allocations so frees can name real runs
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall && sent_items.size() != 0) begin
            done_item = sent_items.pop_front();
            if (done_item.cmd == OP_ALLOC && !o_out_beat.overflow) begin
                live_off.push_back(int'($signed(o_out_beat.frame_offset)));
                live_size.push_back(int'(done_item.size_bytes));
            end
            if (done_item.cmd == OP_ALLOC && o_out_beat.overflow &&
                done_item.size_bytes >= 1 && done_item.size_bytes <= 64)
                map_full_hits++;
            if (done_item.cmd == OP_CLEAR) begin
                live_off.delete();
                live_size.delete();
            end
        end
    end

    function automatic t_in_beat beat_of(logic [1:0] cmd, int size, int off);
        t_in_beat b;
        b.cmd            = cmd;
        b.size_bytes     = 7'(size);
        b.release_offset = 16'(off);
        return b;
    endfunction

    task automatic send_item(input t_in_beat b);
        while ($urandom_range(99) < in_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_items.push_back(b);
        if (b.cmd != OP_NONE) items_sent++;
    endtask

    task automatic free_live_run();
        int idx;
        int off;
        int size;
        idx  = $urandom_range(live_off.size() - 1);
        off  = live_off[idx];
        size = live_size[idx];
        live_off.delete(idx);
        live_size.delete(idx);
        send_item(beat_of(OP_FREE, size, off));
    endtask

    task automatic send_random_item();
        int pick;
        int size;
        pick = $urandom_range(99);
        if (pick < 8) begin
            send_item(beat_of(2'($urandom_range(3)), $urandom_range(127), $urandom));
        end else if (pick < 12) begin
            send_item(beat_of(OP_NONE, $urandom_range(127), $urandom));
        end else if (pick < 14) begin
            send_item(beat_of(OP_CLEAR, $urandom_range(127), $urandom));
        end else if (pick < 56) begin
            size = ($urandom_range(19) == 0) ? $urandom_range(127) : $urandom_range(1, 64);
            send_item(beat_of(OP_ALLOC, size, $urandom));
        end else if (live_off.size() != 0 && $urandom_range(9) < 8) begin
            free_live_run();
        end else begin
            send_item(beat_of(OP_FREE, $urandom_range(1, 64), -int'($urandom_range(16447))));
        end
    endtask

    // large runs until the map refuses one (at most 260 items), with a few holes punched on the way
    task automatic fill_map();
        int start_hits;
        int n;
        start_hits = map_full_hits;
        n          = 0;
        while (map_full_hits == start_hits && n < 260) begin
            if (live_off.size() != 0 && $urandom_range(9) == 0)
                free_live_run();
            else
                send_item(beat_of(OP_ALLOC, $urandom_range(33, 64), $urandom));
            n++;
        end
    endtask

    task automatic set_frame_base(input int value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= FB_W'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        live_off.delete();
        live_size.delete();
    endtask

    task automatic run_phase(input int in_pct, input int out_pct, input int base);
        int phase_start;
        set_frame_base(base);
        pressure_go  = 1'b1;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        phase_start  = items_sent;
        while (items_sent < phase_start + 100) send_random_item();
        fill_map();
        while (items_sent < phase_start + PHASE_ITEMS) send_random_item();
    endtask

    initial begin
        bases[0] = 0;
        bases[1] = 8191;
        bases[2] = $urandom_range(1, 8190);
        bases[3] = $urandom_range(8191);
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_frame_base(bases[0]);
        send_item(beat_of(OP_NONE, 5, 0));
        send_item(beat_of(OP_ALLOC, 1, 0));
        send_item(beat_of(OP_ALLOC, 64, 0));
        send_item(beat_of(OP_ALLOC, 0, 0));
        send_item(beat_of(OP_ALLOC, 65, 0));
        send_item(beat_of(OP_ALLOC, 127, 0));
        send_item(beat_of(OP_FREE, 1, -4));
        send_item(beat_of(OP_ALLOC, 4, 0));
        send_item(beat_of(OP_ALLOC, 8, 0));
        send_item(beat_of(OP_FREE, 4, 32767));
        send_item(beat_of(OP_FREE, 64, -32768));
        // unaligned start byte rounds down, then the same run freed twice
        send_item(beat_of(OP_FREE, 4, -6));
        send_item(beat_of(OP_FREE, 4, -6));
        send_item(beat_of(OP_FREE, 0, -4));
        send_item(beat_of(OP_FREE, 100, -4));
        // hole just under the mark, next run crosses it
        send_item(beat_of(OP_FREE, 8, -76));
        send_item(beat_of(OP_ALLOC, 16, 0));
        send_item(beat_of(OP_CLEAR, 0, 0));
        send_item(beat_of(OP_ALLOC, 64, 0));
        send_item(beat_of(OP_FREE, 1, -1));
        send_item(beat_of(OP_FREE, 64, -(4 * 2040 + 64)));
        send_item(beat_of(OP_FREE, 64, -(4 * 2032 + 64)));
        send_item(beat_of(OP_NONE, 127, -1));

        run_phase(35, 59, bases[1]);
        run_phase(59, 35, bases[2]);
        run_phase(0, 0, bases[3]);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("summary: %0d items, %0d results checked, frame bases %0d %0d %0d %0d",
                 items_sent, checked, bases[0], bases[1], bases[2], bases[3]);
        $display("summary: map exhausted %0d times, one output hold-off of %0d cycles",
                 map_full_hits, LONG_HOLD);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ffsa_pkg.sv
rtl/ffsa_ctrl.sv
rtl/ffsa_dp.sv
rtl/first_fit_stack_slot_allocator.sv
verif/ffsa_slot_checker.sv
verif/tb_first_fit_stack_slot_allocator.sv
